### src/srv_pkg.sv
// ---------------------------------------------------------------------------
// srv_pkg
// Shared widths, register codes and beat types for the refraction pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

  localparam int VEC_FRAC_BITS = 14;

  localparam int V_W        = 16;  // vector component width
  localparam int N_W        = 17;  // flipped normal component width
  localparam int IDX_W      = 14;
  localparam int COEFF_W    = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_ADDR_W = 1;
  localparam int R_W        = 26;  // relative index, scale 2^24
  localparam int R2_W       = 29;  // squared relative index, scale 2^24
  localparam int RAD_W      = 20;
  localparam int CR_W       = 30;  // cosine times index, scale 2^24
  localparam int R_FRAC     = 24;

  localparam int SQ_IN_W    = 56;
  localparam int SQ_OUT_W   = 28;
  localparam int SQ_REM_W   = 30;
  localparam int SQ_BPS     = 2;   // root bits resolved per stage
  localparam int SQ_STAGES  = SQ_OUT_W / SQ_BPS;

  localparam logic [IDX_W-1:0]   IDX_RESET   = 14'd6226;
  localparam logic [IDX_W-1:0]   IDX_ONE     = 14'd4096;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 15'd16384;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_REFRACTIVE_INDEX = 1'b0,
    REG_TRANSMIT_COEFF   = 1'b1
  } cfg_reg_t;

  // Per-side constants derived from the registers
  typedef struct packed {
    logic [R_W-1:0]   r_in;
    logic [R_W-1:0]   r_out;
    logic [R2_W-1:0]  r2_in;
    logic [R2_W-1:0]  r2_out;
    logic [RAD_W-1:0] rad_in;
    logic [RAD_W-1:0] rad_out;
  } cfg_t;

  // Fields that ride along with the square root
  typedef struct packed {
    logic [2:0][N_W-1:0] n;
    logic [2:0][V_W-1:0] o;
    logic                inner;
    logic [R_W-1:0]      r;
    logic [RAD_W-1:0]    rad;
    logic [CR_W-1:0]     cr;
    logic                tir;
  } item_t;

endpackage

`default_nettype wire

### src/srv_in_if.sv
// ---------------------------------------------------------------------------
// srv_in_if
// Input channel: surface normal and outgoing direction.
// ---------------------------------------------------------------------------
`default_nettype none

interface srv_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;

  modport source (output valid, normal_x, normal_y, normal_z, out_x, out_y, out_z,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, out_x, out_y, out_z,
                  output ready);
endinterface

`default_nettype wire

### src/srv_out_if.sv
// ---------------------------------------------------------------------------
// srv_out_if
// Result channel: transmitted direction, radiance scale and flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface srv_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] trans_x;
  logic signed [15:0] trans_y;
  logic signed [15:0] trans_z;
  logic [19:0] radiance_scale;
  logic        inside_hit;
  logic        total_reflect;

  modport source (output valid, trans_x, trans_y, trans_z, radiance_scale, inside_hit,
                  total_reflect, input ready);
  modport sink   (input valid, trans_x, trans_y, trans_z, radiance_scale, inside_hit,
                  total_reflect, output ready);
endinterface

`default_nettype wire

### src/srv_cfg_if.sv
// ---------------------------------------------------------------------------
// srv_cfg_if
// Register write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface srv_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [srv_pkg::CFG_ADDR_W-1:0]     index;
  logic [srv_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/srv_cfg.sv
// ---------------------------------------------------------------------------
// srv_cfg
// Index and coefficient registers; derives reciprocal index, squares and
// radiance scales with a serial divider and one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module srv_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [srv_pkg::CFG_ADDR_W-1:0]  wr_index,
  input  wire logic [srv_pkg::CFG_DATA_W-1:0]  wr_data,
  output srv_pkg::cfg_t                        cfg,
  output logic                                 busy
);

  localparam int NUM_W = 37;           // 2^36 plus half the divisor
  localparam int MUL_W = srv_pkg::R2_W;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_DIV  = 3'b010,
    CS_MUL  = 3'b100
  } cfg_state_t;

  cfg_state_t                       state_r, state_nxt;
  logic [srv_pkg::IDX_W-1:0]        idx_r;
  logic [srv_pkg::COEFF_W-1:0]      coeff_r;
  logic [5:0]                       cnt_r, cnt_nxt;
  logic [1:0]                       mcnt_r, mcnt_nxt;
  logic [srv_pkg::IDX_W-1:0]        rem_r, rem_nxt;
  logic [srv_pkg::R_W-1:0]          q_r, q_nxt;
  logic [srv_pkg::R_W-1:0]          r_out_r;
  logic [srv_pkg::R2_W-1:0]         r2_in_r, r2_out_r;
  logic [srv_pkg::RAD_W-1:0]        rad_in_r, rad_out_r;

  logic [srv_pkg::IDX_W-1:0]        eidx;
  logic [srv_pkg::R_W-1:0]          r_in;
  logic [NUM_W-1:0]                 num;
  logic [srv_pkg::IDX_W:0]          rem_sh;
  logic                             qbit;
  logic [MUL_W-1:0]                 ma, mb;
  logic [2*MUL_W-1:0]               prod;
  logic [2*MUL_W-1:0]               prod_rnd;

  assign eidx = (idx_r < srv_pkg::IDX_ONE) ? srv_pkg::IDX_ONE : idx_r;
  assign r_in = {eidx, 12'd0};
  assign num  = (NUM_W'(1) << 36) + NUM_W'(eidx >> 1);

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_r, num[6'(NUM_W - 1) - cnt_r]};
    qbit   = (rem_sh >= {1'b0, eidx});
    rem_nxt = qbit ? srv_pkg::IDX_W'(rem_sh - {1'b0, eidx}) : rem_sh[srv_pkg::IDX_W-1:0];
    q_nxt   = {q_r[srv_pkg::R_W-2:0], qbit};
  end

  always_comb begin
    unique case (mcnt_r)
      2'd0:    begin ma = MUL_W'(r_in);    mb = MUL_W'(r_in);    end
      2'd1:    begin ma = MUL_W'(r_out_r); mb = MUL_W'(r_out_r); end
      2'd2:    begin ma = MUL_W'(coeff_r); mb = r2_in_r;         end
      default: begin ma = MUL_W'(coeff_r); mb = r2_out_r;        end
    endcase
    prod     = (2*MUL_W)'(ma) * (2*MUL_W)'(mb);
    prod_rnd = (prod + ((2*MUL_W)'(1) << (srv_pkg::R_FRAC - 1))) >> srv_pkg::R_FRAC;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mcnt_nxt  = mcnt_r;
    unique case (state_r)
      CS_IDLE: ;
      CS_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(NUM_W - 1)) begin
          state_nxt = CS_MUL;
          mcnt_nxt  = 2'd0;
        end
      end
      CS_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
    if (wr_en) begin
      state_nxt = CS_DIV;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_DIV;
      cnt_r   <= '0;
      mcnt_r  <= '0;
      rem_r   <= '0;
      idx_r   <= srv_pkg::IDX_RESET;
      coeff_r <= srv_pkg::COEFF_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mcnt_r  <= mcnt_nxt;
      if (wr_en) begin
        rem_r <= '0;
        unique case (srv_pkg::cfg_reg_t'(wr_index))
          srv_pkg::REG_REFRACTIVE_INDEX: idx_r   <= wr_data[srv_pkg::IDX_W-1:0];
          srv_pkg::REG_TRANSMIT_COEFF:   coeff_r <= wr_data[srv_pkg::COEFF_W-1:0];
          default: ;
        endcase
      end else if (state_r == CS_DIV) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CS_DIV) begin
      q_r <= q_nxt;
      if (cnt_r == 6'(NUM_W - 1)) r_out_r <= q_nxt;
    end
    if (state_r == CS_MUL) begin
      unique case (mcnt_r)
        2'd0: r2_in_r  <= srv_pkg::R2_W'(prod_rnd);
        2'd1: r2_out_r <= srv_pkg::R2_W'(prod_rnd);
        2'd2: rad_in_r <= (prod_rnd > (2*MUL_W)'(20'hFFFFF)) ? 20'hFFFFF
                        : srv_pkg::RAD_W'(prod_rnd);
        default: rad_out_r <= (prod_rnd > (2*MUL_W)'(20'hFFFFF)) ? 20'hFFFFF
                            : srv_pkg::RAD_W'(prod_rnd);
      endcase
    end
  end

  assign busy        = (state_r != CS_IDLE);
  assign cfg.r_in    = r_in;
  assign cfg.r_out   = r_out_r;
  assign cfg.r2_in   = r2_in_r;
  assign cfg.r2_out  = r2_out_r;
  assign cfg.rad_in  = rad_in_r;
  assign cfg.rad_out = rad_out_r;

endmodule

`default_nettype wire

### src/srv_front.sv
// ---------------------------------------------------------------------------
// srv_front
// Six stages: dot product, cosine and side, squares, sine, reflection test
// and radicand for the transmitted cosine.
// ---------------------------------------------------------------------------
`default_nettype none

module srv_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  output logic                              up_ready,
  input  wire logic signed [15:0]           n_x,
  input  wire logic signed [15:0]           n_y,
  input  wire logic signed [15:0]           n_z,
  input  wire logic signed [15:0]           o_x,
  input  wire logic signed [15:0]           o_y,
  input  wire logic signed [15:0]           o_z,
  input  wire srv_pkg::cfg_t                cfg,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output logic [srv_pkg::SQ_IN_W-1:0]       dn_rad,
  output srv_pkg::item_t                    dn_item
);

  localparam int F     = srv_pkg::VEC_FRAC_BITS;
  localparam int CF_W  = 34 - F;
  localparam int C2_W  = 2 * CF_W;
  localparam int CMP_W = (C2_W > 2 * F + 1) ? C2_W : 2 * F + 1;
  localparam int CRP_W = CF_W + srv_pkg::R_W + 1;
  localparam int P_W   = 31 + srv_pkg::R2_W;

  logic [5:0] v_r;
  logic [5:0] en;

  assign en[5] = !v_r[5] || dn_ready;
  assign en[4] = !v_r[4] || en[5];
  assign en[3] = !v_r[3] || en[4];
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= take;
      for (int k = 1; k < 6; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage A: component products
  logic signed [15:0] a_n_r [3];
  logic signed [15:0] a_o_r [3];
  logic signed [31:0] a_p_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_n_r[0] <= n_x; a_n_r[1] <= n_y; a_n_r[2] <= n_z;
      a_o_r[0] <= o_x; a_o_r[1] <= o_y; a_o_r[2] <= o_z;
      a_p_r[0] <= n_x * o_x;
      a_p_r[1] <= n_y * o_y;
      a_p_r[2] <= n_z * o_z;
    end
  end

  // stage B: sum, side, flip, cosine magnitude
  logic signed [33:0] dot;
  logic [33:0]        mag;
  logic [33:0]        mag_rnd;
  srv_pkg::item_t     b_it_nxt, b_it_r;
  logic [CF_W-1:0]    b_cf_r;

  always_comb begin
    dot      = 34'(a_p_r[0]) + 34'(a_p_r[1]) + 34'(a_p_r[2]);
    mag      = dot[33] ? 34'(-dot) : 34'(dot);
    mag_rnd  = (mag + (34'(1) << (F - 1))) >> F;
    b_it_nxt = '0;
    b_it_nxt.inner = dot[33];
    for (int i = 0; i < 3; i++) begin
      b_it_nxt.n[i] = dot[33] ? -17'(a_n_r[i]) : 17'(a_n_r[i]);
      b_it_nxt.o[i] = a_o_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_it_r <= b_it_nxt;
      b_cf_r <= CF_W'(mag_rnd);
    end
  end

  // stage C: pick side constants, square cosine, scale by index
  logic [C2_W-1:0]           c2;
  logic [CRP_W-1:0]          crp;
  logic [srv_pkg::R_W-1:0]   rs;
  srv_pkg::item_t            c_it_nxt, c_it_r;
  logic [C2_W-1:0]           c_c2_r;
  logic [CRP_W-1:0]          c_crp_r;
  logic [srv_pkg::R2_W-1:0]  c_r2_r;

  always_comb begin
    rs       = b_it_r.inner ? cfg.r_in : cfg.r_out;
    c2       = C2_W'(b_cf_r) * C2_W'(b_cf_r);
    crp      = CRP_W'(b_cf_r) * CRP_W'(rs);
    c_it_nxt = b_it_r;
    c_it_nxt.r   = rs;
    c_it_nxt.rad = b_it_r.inner ? cfg.rad_in : cfg.rad_out;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_it_r  <= c_it_nxt;
      c_c2_r  <= c2;
      c_crp_r <= crp;
      c_r2_r  <= b_it_r.inner ? cfg.r2_in : cfg.r2_out;
    end
  end

  // stage D: squared sine to scale 2^30, cosine times index to scale 2^24
  logic [CMP_W-1:0]          one;
  logic [CMP_W-1:0]          c2e;
  logic [CMP_W-1:0]          s2;
  logic [30:0]               s30;
  logic [CRP_W-1:0]          cr_rnd;
  srv_pkg::item_t            d_it_nxt, d_it_r;
  logic [30:0]               d_s30_r;
  logic [srv_pkg::R2_W-1:0]  d_r2_r;

  always_comb begin
    one    = CMP_W'(1) << (2 * F);
    c2e    = CMP_W'(c_c2_r);
    s2     = (c2e < one) ? one - c2e : '0;
    cr_rnd = (c_crp_r + (CRP_W'(1) << (F - 1))) >> F;
    d_it_nxt    = c_it_r;
    d_it_nxt.cr = srv_pkg::CR_W'(cr_rnd);
  end

  generate
    if (2 * F > 30) begin : g_s2_down
      always_comb s30 = 31'((s2 + (CMP_W'(1) << (2 * F - 31))) >> (2 * F - 30));
    end else if (2 * F == 30) begin : g_s2_same
      always_comb s30 = 31'(s2);
    end else begin : g_s2_up
      always_comb s30 = 31'(s2) << (30 - 2 * F);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_it_r  <= d_it_nxt;
      d_s30_r <= s30;
      d_r2_r  <= c_r2_r;
    end
  end

  // stage E: sine squared times index squared
  srv_pkg::item_t e_it_r;
  logic [P_W-1:0] e_p_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_it_r <= d_it_r;
      e_p_r  <= P_W'(d_s30_r) * P_W'(d_r2_r);
    end
  end

  // stage F: reflection test and radicand
  localparam logic [P_W-1:0] LIM = P_W'(1) << 54;
  logic                      tir;
  srv_pkg::item_t            f_it_nxt, f_it_r;
  logic [srv_pkg::SQ_IN_W-1:0] f_rad_r;

  always_comb begin
    tir          = (e_p_r > LIM);
    f_it_nxt     = e_it_r;
    f_it_nxt.tir = tir;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f_it_r  <= f_it_nxt;
      f_rad_r <= tir ? '0 : srv_pkg::SQ_IN_W'(LIM - e_p_r);
    end
  end

  assign dn_valid = v_r[5];
  assign dn_rad   = f_rad_r;
  assign dn_item  = f_it_r;

endmodule

`default_nettype wire

### src/srv_sqrt.sv
// ---------------------------------------------------------------------------
// srv_sqrt
// Pipelined integer square root, two root bits per stage, carrying the beat.
// ---------------------------------------------------------------------------
`default_nettype none

module srv_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire logic [srv_pkg::SQ_IN_W-1:0]   up_rad,
  input  wire srv_pkg::item_t                up_item,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output logic [srv_pkg::SQ_OUT_W-1:0]       dn_root,
  output srv_pkg::item_t                     dn_item
);

  localparam int NS  = srv_pkg::SQ_STAGES;
  localparam int RW  = srv_pkg::SQ_REM_W;
  localparam int QW  = srv_pkg::SQ_OUT_W;
  localparam int XW  = srv_pkg::SQ_IN_W;

  logic [NS-1:0]   v_r;
  logic [NS-1:0]   en;
  logic [RW-1:0]   rem_r  [NS];
  logic [QW-1:0]   root_r [NS];
  logic [XW-1:0]   x_r    [NS];
  srv_pkg::item_t  it_r   [NS];

  assign en[NS-1] = !v_r[NS-1] || dn_ready;
  assign up_ready = en[0];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stg
      logic [RW-1:0]  rem_i;
      logic [QW-1:0]  root_i;
      logic [XW-1:0]  x_i;
      srv_pkg::item_t it_i;
      logic           v_i;
      logic [RW-1:0]  rem_o;
      logic [QW-1:0]  root_o;
      logic [XW-1:0]  x_o;
      logic [RW+1:0]  rem_sh;
      logic [RW+1:0]  trial;

      if (k == 0) begin : g_head
        assign rem_i  = '0;
        assign root_i = '0;
        assign x_i    = up_rad;
        assign it_i   = up_item;
        assign v_i    = up_valid;
      end else begin : g_body
        assign rem_i  = rem_r[k-1];
        assign root_i = root_r[k-1];
        assign x_i    = x_r[k-1];
        assign it_i   = it_r[k-1];
        assign v_i    = v_r[k-1];
      end

      if (k < NS - 1) begin : g_en
        assign en[k] = !v_r[k] || en[k+1];
      end

      always_comb begin
        rem_o  = rem_i;
        root_o = root_i;
        x_o    = x_i;
        for (int j = 0; j < srv_pkg::SQ_BPS; j++) begin
          rem_sh = {rem_o, x_o[XW-1 -: 2]};
          trial  = {root_o, 2'b01};
          if (rem_sh >= trial) begin
            rem_o  = RW'(rem_sh - trial);
            root_o = {root_o[QW-2:0], 1'b1};
          end else begin
            rem_o  = rem_sh[RW-1:0];
            root_o = {root_o[QW-2:0], 1'b0};
          end
          x_o = x_o << 2;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= v_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k]  <= rem_o;
          root_r[k] <= root_o;
          x_r[k]    <= x_o;
          it_r[k]   <= it_i;
        end
      end
    end
  endgenerate

  assign dn_valid = v_r[NS-1];
  assign dn_root  = root_r[NS-1];
  assign dn_item  = it_r[NS-1];

endmodule

`default_nettype wire

### src/srv_back.sv
// ---------------------------------------------------------------------------
// srv_back
// Direction assembly: normal gain, component products, sums, rounding and
// saturation into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module srv_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [srv_pkg::SQ_OUT_W-1:0] up_root,
  input  wire srv_pkg::item_t               up_item,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output logic signed [15:0]                trans_x,
  output logic signed [15:0]                trans_y,
  output logic signed [15:0]                trans_z,
  output logic [srv_pkg::RAD_W-1:0]         radiance_scale,
  output logic                              inside_hit,
  output logic                              total_reflect
);

  logic [3:0] v_r;
  logic [3:0] en;

  assign en[3] = !v_r[3] || dn_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < 4; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage G: normal gain = c*r - transmitted cosine
  logic [25:0]        cost;
  logic signed [30:0] g;
  logic signed [30:0] g_g_r;
  srv_pkg::item_t     g_it_r;

  always_comb begin
    cost = 26'((29'(up_root) + 29'd4) >> 3);
    g    = $signed({1'b0, up_item.cr}) - $signed({5'b0, cost});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      g_g_r  <= g;
      g_it_r <= up_item;
    end
  end

  // stage H: component products
  logic signed [42:0] h_orp_r [3];
  logic signed [47:0] h_gn_r  [3];
  srv_pkg::item_t     h_it_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      h_it_r <= g_it_r;
      for (int i = 0; i < 3; i++) begin
        h_orp_r[i] <= $signed(g_it_r.o[i]) * $signed({1'b0, g_it_r.r});
        h_gn_r[i]  <= g_g_r * $signed(g_it_r.n[i]);
      end
    end
  end

  // stage I: sums
  logic signed [48:0] i_acc_r [3];
  srv_pkg::item_t     i_it_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      i_it_r <= h_it_r;
      for (int i = 0; i < 3; i++) begin
        i_acc_r[i] <= 49'(h_gn_r[i]) - 49'(h_orp_r[i]);
      end
    end
  end

  // stage J: round to nearest with ties away from zero, saturate, zero on reflection
  logic [48:0]        mag  [3];
  logic [25:0]        q    [3];
  logic signed [15:0] sat  [3];
  logic signed [15:0] t_r  [3];
  logic [srv_pkg::RAD_W-1:0] rad_r;
  logic               inner_r;
  logic               tir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = i_acc_r[i][48] ? 49'(-i_acc_r[i]) : 49'(i_acc_r[i]);
      q[i]   = 26'((mag[i] + (49'(1) << (srv_pkg::R_FRAC - 1))) >> srv_pkg::R_FRAC);
      if (!i_acc_r[i][48]) begin
        sat[i] = (q[i] > 26'd32767) ? 16'sh7FFF : $signed(q[i][15:0]);
      end else begin
        sat[i] = (q[i] > 26'd32768) ? 16'sh8000 : $signed(16'(~q[i] + 26'd1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= i_it_r.tir ? 16'sd0 : sat[i];
      end
      rad_r   <= i_it_r.tir ? '0 : i_it_r.rad;
      inner_r <= i_it_r.inner;
      tir_r   <= i_it_r.tir;
    end
  end

  assign dn_valid       = v_r[3];
  assign trans_x        = t_r[0];
  assign trans_y        = t_r[1];
  assign trans_z        = t_r[2];
  assign radiance_scale = rad_r;
  assign inside_hit     = inner_r;
  assign total_reflect  = tir_r;

endmodule

`default_nettype wire

### src/snell_refraction_vector.sv
// ---------------------------------------------------------------------------
// snell_refraction_vector
// Refracted direction and radiance scale by Snell's law, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      beat contents
//  in_if     in   valid/ready    normal_x/y/z, out_x/y/z
//  out_if    out  valid/ready    trans_x/y/z, radiance_scale, inside_hit,
//                                total_reflect
//  cfg_if    in   valid/ready    index, data (0: refractive_index,
//                                1: transmit_coeff)
//
// One beat enters per cycle while out_if accepts results and no register update
// is in progress; the 14-stage square root sits between the reflection test and
// direction assembly. After reset and after every register write, in_if.ready
// stays low while the serial divider and then the shared multiplier rebuild the
// per-side index constants. cfg_if.ready is always high.
// A stall on out_if backs up stage by stage; bubbles are squeezed out.
// ---------------------------------------------------------------------------
`default_nettype none

module snell_refraction_vector (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srv_in_if.sink     in_if,
  srv_out_if.source  out_if,
  srv_cfg_if.sink    cfg_if
);

  srv_pkg::cfg_t                    cfg;
  logic                             busy;
  logic                             front_ready;
  logic                             take;
  logic                             f_valid, f_ready;
  logic [srv_pkg::SQ_IN_W-1:0]      f_rad;
  srv_pkg::item_t                   f_item;
  logic                             s_valid, s_ready;
  logic [srv_pkg::SQ_OUT_W-1:0]     s_root;
  srv_pkg::item_t                   s_item;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = front_ready && !busy;
  assign take         = in_if.valid && in_if.ready;

  srv_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid && cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg),
    .busy     (busy)
  );

  srv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .up_ready (front_ready),
    .n_x      (in_if.normal_x),
    .n_y      (in_if.normal_y),
    .n_z      (in_if.normal_z),
    .o_x      (in_if.out_x),
    .o_y      (in_if.out_y),
    .o_z      (in_if.out_z),
    .cfg      (cfg),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_rad   (f_rad),
    .dn_item  (f_item)
  );

  srv_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_rad   (f_rad),
    .up_item  (f_item),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .dn_root  (s_root),
    .dn_item  (s_item)
  );

  srv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (s_valid),
    .up_ready       (s_ready),
    .up_root        (s_root),
    .up_item        (s_item),
    .dn_valid       (out_if.valid),
    .dn_ready       (out_if.ready),
    .trans_x        (out_if.trans_x),
    .trans_y        (out_if.trans_y),
    .trans_z        (out_if.trans_z),
    .radiance_scale (out_if.radiance_scale),
    .inside_hit     (out_if.inside_hit),
    .total_reflect  (out_if.total_reflect)
  );

endmodule

`default_nettype wire
